/* rtl/core/pfrc_pkg.sv */
// Shared types and constants of the packet field rate-to-code block.
package pfrc_pkg;

  // Character codes
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_AT     = 8'h40;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_POINT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // Configuration register indexes and reset values
  localparam logic [7:0] REG_FIELD_OFFSET = 8'd0;
  localparam logic [7:0] REG_FIELD_LENGTH = 8'd1;
  localparam logic [7:0] FIELD_OFFSET_RST = 8'd112;
  localparam logic [4:0] FIELD_LENGTH_RST = 5'd9;

  // Fixed-point scaling
  localparam int unsigned ACC_W       = 30;
  localparam int unsigned MAG_W       = 31;
  localparam int unsigned PROD_W      = 56;
  localparam int unsigned SUM_W       = 57;
  localparam logic [ACC_W-1:0] ACC_MAX = 30'h3FFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_DIGIT_LIMIT = 30'd107374181;
  localparam logic [MAG_W-1:0] VAL_MAX = 31'h7FFF_FFFF;
  localparam logic signed [24:0] RATE_COEF = 25'sd12599283;
  localparam logic signed [SUM_W-1:0] CODE_OFFSET = 57'sd549747425280;
  localparam logic [2:0] FRAC_DIGITS = 3'd4;
  localparam logic [15:0] CODE_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MUL,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic take_char;
    logic start_commit;
    logic scale_step;
    logic commit_load;
    logic mul_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_is_at;
    logic scale_done;
    logic out_busy;
  } status_t;

endpackage

/* rtl/core/pfrc_ifs.sv */
// Valid/ready channel interfaces: characters, result codes and register writes.
interface pfrc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfrc_code_if;
  logic        valid;
  logic        ready;
  logic [15:0] rate_code;
  logic        clipped;
  modport source (output valid, output rate_code, output clipped, input ready);
  modport sink   (input valid, input rate_code, input clipped, output ready);
endinterface

interface pfrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/packet_field_rate_to_code_unit.sv */
// Top level of the packet field rate-to-code block.
//
// Usage: characters arrive one per beat on the chars channel. A '$' opens a
// packet at position 0; the characters at positions field_offset through
// field_offset+field_length-1 are parsed as a signed decimal rate in rad/s
// (sign, digits, point, up to four fraction digits). A '@' closes the packet
// and produces one beat on the codes channel: a 16-bit offset-binary code
// (-250..+250 deg/s onto 0..65535) plus a clip flag. No other character
// produces a result beat.
// Sequence: a plain character is taken on its beat whenever the unit is idle. A '@'
// keeps the input closed after its beat through decimal scaling of up to four decades
// (one decade per cycle through the times-ten unit), a step that loads the signed
// value, the 32x25 multiply and the offset and clip stage; the result is then held
// in the output register.
// The cfg channel is always ready; write registers only while idle.
// Reset: synchronous, active high; clears capture and parse state, the held
// value to zero, and restores field_offset 112 and field_length 9.
// Stall: the code sits in an output register, so the next characters are
// taken while a receiver stalls; a following '@' waits in the clip stage.
module packet_field_rate_to_code_unit
  import pfrc_pkg::*;
#(
  parameter int PACKET_CHARS = 144
) (
  input logic         clk,
  input logic         rst,
  pfrc_cfg_if.sink    cfg,
  pfrc_char_if.sink   chars,
  pfrc_code_if.source codes
);

  cmd_t    cmd;
  status_t status;

  // register writes never stall
  assign cfg.ready = 1'b1;

  pfrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (chars.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfrc_datapath #(
    .PACKET_CHARS (PACKET_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .rx_byte   (chars.rx_byte),
    .cfg_write (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (codes.ready),
    .out_valid (codes.valid),
    .rate_code (codes.rate_code),
    .clipped   (codes.clipped)
  );

endmodule

/* rtl/core/pfrc_ctrl.sv */
// Sequencer: accepts beats and steps the scale, commit, multiply and clip phases.
module pfrc_ctrl
  import pfrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (status.in_is_at) begin
            cmd.start_commit = 1'b1;
            state_next       = ST_SCALE;
          end else begin
            cmd.take_char = 1'b1;
          end
        end
      end
      ST_SCALE: begin
        if (status.scale_done) begin
          cmd.commit_load = 1'b1;
          state_next      = ST_MUL;
        end else begin
          cmd.scale_step = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = ST_FINAL;
      end
      ST_FINAL: begin
        // hold until the output register frees up
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/pfrc_datapath.sv */
// Config registers, parser, fixed-point scaler, multiplier, clip stage and output register.
module pfrc_datapath
  import pfrc_pkg::*;
#(
  parameter int PACKET_CHARS = 144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [15:0] rate_code,
  output logic        clipped
);

  localparam logic [8:0] PACKET_LIMIT = 9'(PACKET_CHARS);

  logic [7:0]       field_offset;
  logic [4:0]       field_length;
  logic             capturing, capturing_next;
  logic [7:0]       char_position, char_position_next;
  phase_t           parse_phase, parse_phase_next;
  logic             is_negative, is_negative_next;
  logic [ACC_W-1:0] digit_accumulator, digit_accumulator_next;
  logic [2:0]       fraction_count, fraction_count_next;
  logic signed [31:0] parsed_value;

  logic             commit_en;
  logic             commit_neg;
  logic [2:0]       scale_count;
  logic [MAG_W-1:0] mag;
  logic [MAG_W+3:0] mag_x10;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  total;
  logic [32:0]      code_wide;

  logic             is_digit;
  logic [3:0]       digit;
  logic [ACC_W-1:0] acc_digit;
  logic             in_field;
  logic [7:0]       rel_pos;
  logic [8:0]       pos_inc;

  function automatic logic [ACC_W-1:0] add_digit(logic [ACC_W-1:0] acc, logic [3:0] d);
    if (acc > ACC_DIGIT_LIMIT) begin
      return ACC_MAX;
    end
    return ACC_W'(acc * ACC_W'(10) + ACC_W'(d));
  endfunction

  assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
  assign digit     = 4'(rx_byte - CHAR_ZERO);
  // a '$' is never a digit, so the step always builds on the held accumulator
  assign acc_digit = add_digit(digit_accumulator, digit);

  assign status.in_is_at   = (rx_byte == CHAR_AT);
  assign status.scale_done = !commit_en || (scale_count == FRAC_DIGITS);
  assign status.out_busy   = out_valid && !out_ready;

  // character parse
  always_comb begin
    capturing_next         = capturing;
    char_position_next     = char_position;
    parse_phase_next       = parse_phase;
    is_negative_next       = is_negative;
    digit_accumulator_next = digit_accumulator;
    fraction_count_next    = fraction_count;
    rel_pos                = '0;
    in_field               = 1'b0;
    pos_inc                = '0;
    if (cmd.take_char) begin
      if (rx_byte == CHAR_DOLLAR) begin
        capturing_next         = 1'b1;
        char_position_next     = '0;
        parse_phase_next       = PH_SIGN;
        is_negative_next       = 1'b0;
        digit_accumulator_next = '0;
        fraction_count_next    = '0;
      end
      if (capturing_next) begin
        rel_pos  = char_position_next - field_offset;
        in_field = (char_position_next >= field_offset) && (rel_pos < {3'b000, field_length});
        if (in_field) begin
          unique case (parse_phase_next)
            PH_SIGN: begin
              if (rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS) begin
                is_negative_next = (rx_byte == CHAR_MINUS);
                parse_phase_next = PH_INT;
              end else if (is_digit) begin
                digit_accumulator_next = acc_digit;
                parse_phase_next       = PH_INT;
              end else if (rx_byte == CHAR_POINT) begin
                parse_phase_next = PH_FRAC;
              end else begin
                parse_phase_next = PH_STOP;
              end
            end
            PH_INT: begin
              if (is_digit) begin
                digit_accumulator_next = acc_digit;
              end else if (rx_byte == CHAR_POINT) begin
                parse_phase_next = PH_FRAC;
              end else begin
                parse_phase_next = PH_STOP;
              end
            end
            PH_FRAC: begin
              if (is_digit) begin
                if (fraction_count_next < FRAC_DIGITS) begin
                  digit_accumulator_next = acc_digit;
                  fraction_count_next    = fraction_count_next + 3'd1;
                end
              end else begin
                parse_phase_next = PH_STOP;
              end
            end
            PH_STOP: parse_phase_next = PH_STOP;
            default: parse_phase_next = PH_STOP;
          endcase
        end
        pos_inc = {1'b0, char_position_next} + 9'd1;
        if (pos_inc >= PACKET_LIMIT) begin
          capturing_next = 1'b0;
        end
        char_position_next = pos_inc[7:0];
      end
    end else if (cmd.start_commit) begin
      capturing_next         = 1'b0;
      char_position_next     = '0;
      parse_phase_next       = PH_SIGN;
      is_negative_next       = 1'b0;
      digit_accumulator_next = '0;
      fraction_count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_offset      <= FIELD_OFFSET_RST;
      field_length      <= FIELD_LENGTH_RST;
      capturing         <= 1'b0;
      char_position     <= '0;
      parse_phase       <= PH_SIGN;
      is_negative       <= 1'b0;
      digit_accumulator <= '0;
      fraction_count    <= '0;
      parsed_value      <= '0;
      commit_en         <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FIELD_OFFSET: field_offset <= cfg_data;
          REG_FIELD_LENGTH: field_length <= cfg_data[4:0];
          default: ;
        endcase
      end
      capturing         <= capturing_next;
      char_position     <= char_position_next;
      parse_phase       <= parse_phase_next;
      is_negative       <= is_negative_next;
      digit_accumulator <= digit_accumulator_next;
      fraction_count    <= fraction_count_next;
      if (cmd.start_commit) begin
        commit_en <= (parse_phase != PH_SIGN);
      end
      if (cmd.commit_load && commit_en) begin
        parsed_value <= commit_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scale the digits up to four fraction places, one decade a cycle
  assign mag_x10 = (MAG_W+4)'(mag) * (MAG_W+4)'(10);

  always_ff @(posedge clk) begin
    if (cmd.start_commit) begin
      mag         <= MAG_W'(digit_accumulator);
      scale_count <= fraction_count;
      commit_neg  <= is_negative;
    end else if (cmd.scale_step) begin
      mag         <= (mag_x10 > (MAG_W+4)'(VAL_MAX)) ? VAL_MAX : mag_x10[MAG_W-1:0];
      scale_count <= scale_count + 3'd1;
    end
    if (cmd.mul_load) begin
      prod <= parsed_value * RATE_COEF;
    end
  end

  // offset, shift and saturate
  assign total     = SUM_W'(prod) + CODE_OFFSET;
  assign code_wide = total[SUM_W-1:24];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (total < 0) begin
        rate_code <= '0;
        clipped   <= 1'b1;
      end else if (code_wide > 33'(CODE_MAX)) begin
        rate_code <= CODE_MAX;
        clipped   <= 1'b1;
      end else begin
        rate_code <= code_wide[15:0];
        clipped   <= 1'b0;
      end
    end
  end

endmodule

/* tb/sv/tb_packet_field_rate_to_code_unit.sv */
// Testbench for the packet field rate-to-code unit: predicts each code beat and checks it.
module tb_packet_field_rate_to_code_unit;
  import pfrc_pkg::*;

  localparam int PKT_CHARS     = 144;
  localparam int ITEM_TARGET   = 1650;
  localparam int CYCLE_LIMIT   = 400000;
  // A '@' keeps the unit busy through scaling, load, multiply and clip before the output register.
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_OFF_CYCLES = 300;

  // Q0.24 factor that turns 1e-4 rad/s into code steps, and the 32767.5 offset in Q24
  localparam longint RATE_Q24  = 64'sd12599283;
  localparam longint CODE_BIAS = 64'sd549747425280;
  localparam logic [29:0] DIGIT_ACC_TOP = 30'h3FFF_FFFF;
  localparam longint unsigned RATE_MAG_TOP = 64'd2147483647;

  // Register indexes the unit does not decode
  localparam logic [7:0] REG_SPARE_LOW  = 8'd2;
  localparam logic [7:0] REG_SPARE_HIGH = 8'hFF;

  typedef struct packed {
    logic [15:0] rate_code;
    logic        clipped;
  } code_beat_t;

  logic clk;
  logic rst;

  pfrc_cfg_if  cfg_ch ();
  pfrc_char_if char_ch ();
  pfrc_code_if code_ch ();

  packet_field_rate_to_code_unit #(
    .PACKET_CHARS(PKT_CHARS)
  ) uut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .chars(char_ch),
    .codes(code_ch)
  );

  // ---------------------------------------------------------------------------
  // Rate predictor: register copies, packet tracking and the decimal parse.
  // ---------------------------------------------------------------------------
  logic [7:0]        cfg_offset;
  logic [4:0]        cfg_length;
  logic              in_packet;
  logic [7:0]        pkt_pos;
  phase_t            rate_phase;
  logic              rate_neg;
  logic [29:0]       rate_digits;
  logic [2:0]        rate_frac;
  logic signed [31:0] held_rate;   // units of 1e-4 rad/s

  code_beat_t expected_codes[$];

  // Stimulus and bookkeeping
  logic [7:0] rate_txt[$];
  int         chars_sent = 0;
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         tx_steady = 1'b0;
  int         tx_burst_left = 0;

  // Receiver stall control; tests request a hold-off through the tag
  int         rx_hold_len = 0;
  logic [7:0] rx_hold_tag = 8'd0;
  logic [7:0] rx_hold_seen = 8'd0;
  int         rx_hold_left = 0;
  int         rx_mode = 0;
  int         rx_mode_left = 0;
  logic [7:0] rx_mask = 8'hFF;
  int         rx_slot = 0;

  function automatic void clear_rate_parse();
    rate_phase  = PH_SIGN;
    rate_neg    = 1'b0;
    rate_digits = '0;
    rate_frac   = '0;
  endfunction

  function automatic void reset_predictor();
    cfg_offset = FIELD_OFFSET_RST;
    cfg_length = FIELD_LENGTH_RST;
    in_packet  = 1'b0;
    pkt_pos    = '0;
    held_rate  = '0;
    clear_rate_parse();
  endfunction

  // Accumulate one decimal digit; pin at the top once another would overflow.
  function automatic void shift_in_digit(input logic [7:0] c);
    if (rate_digits > (DIGIT_ACC_TOP - 30'd9) / 30'd10) begin
      rate_digits = DIGIT_ACC_TOP;
    end else begin
      rate_digits = rate_digits * 30'd10 + 30'(c - CHAR_ZERO);
    end
  endfunction

  function automatic void parse_rate_char(input logic [7:0] c);
    logic is_digit;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (rate_phase)
      PH_SIGN: begin
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          rate_neg   = (c == CHAR_MINUS);
          rate_phase = PH_INT;
        end else if (is_digit) begin
          shift_in_digit(c);
          rate_phase = PH_INT;
        end else if (c == CHAR_POINT) begin
          rate_phase = PH_FRAC;
        end else begin
          rate_phase = PH_STOP;
        end
      end
      PH_INT: begin
        if (is_digit) shift_in_digit(c);
        else if (c == CHAR_POINT) rate_phase = PH_FRAC;
        else rate_phase = PH_STOP;
      end
      PH_FRAC: begin
        if (is_digit) begin
          // digits past the fourth fraction place are dropped, not fatal
          if (rate_frac < FRAC_DIGITS) begin
            shift_in_digit(c);
            rate_frac = rate_frac + 3'd1;
          end
        end else begin
          rate_phase = PH_STOP;
        end
      end
      default: ;
    endcase
  endfunction

  // Scale the digits to four fraction places and hold the signed result.
  function automatic void latch_held_rate();
    longint unsigned mag;
    int k;
    mag = rate_digits;
    for (k = rate_frac; k < 4; k++) mag = mag * 10;
    if (mag > RATE_MAG_TOP) mag = RATE_MAG_TOP;
    held_rate = mag[31:0];
    if (rate_neg) held_rate = -held_rate;
  endfunction

  function automatic code_beat_t held_rate_code();
    longint scaled;
    code_beat_t beat;
    scaled = longint'(held_rate) * RATE_Q24 + CODE_BIAS;
    if (scaled < 0) begin
      beat.rate_code = 16'd0;
      beat.clipped   = 1'b1;
    end else if ((scaled >>> 24) > 64'sd65535) begin
      beat.rate_code = CODE_MAX;
      beat.clipped   = 1'b1;
    end else begin
      beat.rate_code = scaled[39:24];
      beat.clipped   = 1'b0;
    end
    return beat;
  endfunction

  // Advance the predictor by one accepted character; return 1 when a code beat follows.
  function automatic bit track_char(input logic [7:0] c, output code_beat_t beat);
    beat = '0;
    if (c == CHAR_AT) begin
      // an untouched field keeps the held rate
      if (rate_phase != PH_SIGN) latch_held_rate();
      in_packet = 1'b0;
      pkt_pos   = '0;
      clear_rate_parse();
      beat = held_rate_code();
      return 1'b1;
    end
    if (c == CHAR_DOLLAR) begin
      in_packet = 1'b1;
      pkt_pos   = '0;
      clear_rate_parse();
    end
    if (in_packet) begin
      if (pkt_pos >= cfg_offset && int'(pkt_pos) - int'(cfg_offset) < int'(cfg_length))
        parse_rate_char(c);
      // stop capturing once the packet runs past its length
      if (int'(pkt_pos) + 1 >= PKT_CHARS) in_packet = 1'b0;
      pkt_pos = pkt_pos + 8'd1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit and receiver.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_packet_field_rate_to_code_unit failed");
      $finish;
    end
  end

  // Drive codes ready: switch among stall styles now and then, and honor a
  // requested hold-off by counting it down cycle by cycle.
  always @(posedge clk) begin : drive_code_ready
    logic rdy;
    if (rx_hold_tag != rx_hold_seen) begin
      rx_hold_seen = rx_hold_tag;
      rx_hold_left = rx_hold_len;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(32, 400);
      rx_mask      = 8'($urandom_range(1, 255));
    end else begin
      rx_mode_left--;
    end
    rx_slot = (rx_slot + 1) % 8;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = rx_mask[rx_slot];
        default: rdy = ($urandom_range(0, 4) == 0);
      endcase
    end
    code_ch.ready <= rdy;
  end

  task automatic report_failure(input string what, input code_beat_t want,
                                input code_beat_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected code %0d clip %0b, got code %0d clip %0b",
               what, want.rate_code, want.clipped, got.rate_code, got.clipped);
  endtask

  // Compare every accepted code beat with the oldest prediction.
  always @(posedge clk) begin : check_codes
    code_beat_t want;
    code_beat_t got;
    if (!rst && code_ch.valid && code_ch.ready) begin
      got.rate_code = code_ch.rate_code;
      got.clipped   = code_ch.clipped;
      if (expected_codes.size() == 0) begin
        report_failure("code beat with nothing expected", '0, got);
      end else begin
        want = expected_codes.pop_front();
        if (got.rate_code !== want.rate_code || got.clipped !== want.clipped)
          report_failure("code beat mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] filler_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CHAR_DOLLAR || c == CHAR_AT);
    return c;
  endfunction

  // Offer one character and hold it until accepted. Bursts of random length
  // are separated by random gaps unless the sender runs steady.
  task automatic send_char(input logic [7:0] c);
    int gap;
    code_beat_t beat;
    if (!tx_steady && tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        char_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (tx_burst_left != 0) tx_burst_left--;
    char_ch.valid   <= 1'b1;
    char_ch.rx_byte <= c;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
    if (track_char(c, beat)) expected_codes.push_back(beat);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_packet_text(input string body);
    send_char(CHAR_DOLLAR);
    send_text(body);
    send_char(CHAR_AT);
  endtask

  task automatic send_filler(input int n);
    int i;
    for (i = 0; i < n; i++) send_char(filler_char());
  endtask

  // Drop valid, wait out every pending code beat, then let the unit settle.
  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    tx_burst_left = 0;
    while (expected_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_FIELD_OFFSET) cfg_offset = val;
    else if (idx == REG_FIELD_LENGTH) cfg_length = val[4:0];
  endtask

  // Build a rate field: mostly well-formed decimals, some garbage.
  function automatic void build_rate_text();
    int r;
    int n;
    int i;
    rate_txt.delete();
    r = $urandom_range(0, 99);
    if (r < 85) begin
      case ($urandom_range(0, 2))
        1: rate_txt.push_back(CHAR_PLUS);
        2: rate_txt.push_back(CHAR_MINUS);
        default: ;
      endcase
      r = $urandom_range(0, 99);
      // one small integer digit stays mostly in range; long runs saturate
      n = (r < 70) ? 1 : (r < 85) ? 0 : (r < 95) ? $urandom_range(2, 3) : $urandom_range(4, 12);
      for (i = 0; i < n; i++)
        rate_txt.push_back(CHAR_ZERO + 8'((n == 1) ? $urandom_range(0, 5) : $urandom_range(0, 9)));
      if ($urandom_range(0, 4) != 0) begin
        rate_txt.push_back(CHAR_POINT);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++) rate_txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 4) == 0) rate_txt.push_back(filler_char());
    end else begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 4))
          0: rate_txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          1: rate_txt.push_back(CHAR_PLUS);
          2: rate_txt.push_back(CHAR_MINUS);
          3: rate_txt.push_back(CHAR_POINT);
          default: rate_txt.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endfunction

  // Send '$', filler up to the field, a rate field, a short tail and,
  // when asked, the closing '@'. An unreachable field gets a short packet.
  task automatic send_rate_packet(input bit close);
    int i;
    build_rate_text();
    send_char(CHAR_DOLLAR);
    if (cfg_offset < PKT_CHARS && cfg_offset > 0) send_filler(cfg_offset - 1);
    for (i = 0; i < rate_txt.size(); i++) send_char(rate_txt[i]);
    send_filler($urandom_range(0, 2));
    if (close) send_char(CHAR_AT);
  endtask

  // Pick a new field layout, mostly near the packet start.
  task automatic retune_field();
    int r;
    logic [7:0] off;
    logic [4:0] len;
    r = $urandom_range(0, 99);
    off = 8'((r < 60) ? $urandom_range(0, 6) : (r < 85) ? $urandom_range(7, 20) :
             (r < 93) ? $urandom_range(0, 1) : $urandom_range(PKT_CHARS, 255));
    r = $urandom_range(0, 99);
    len = 5'((r < 75) ? $urandom_range(1, 16) : (r < 85) ? 0 : $urandom_range(17, 31));
    write_reg(REG_FIELD_OFFSET, off);
    // upper data bits are don't-care for the length register
    write_reg(REG_FIELD_LENGTH, {3'($urandom_range(0, 7)), len});
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_LOW, 8'($urandom_range(0, 255)));
    tx_steady = ($urandom_range(0, 4) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset layout: a stray '@' reports the cleared rate, then two packets
  // parse at the reset offset and length.
  task automatic test_reset_layout();
    send_char(CHAR_AT);
    send_rate_packet(1'b1);
    send_rate_packet(1'b1);
  endtask

  task automatic test_directed_cases();
    write_reg(REG_FIELD_OFFSET, 8'd1);
    write_reg(REG_FIELD_LENGTH, 8'd16);
    // lowest rate on the scale; the fifth fraction digit is dropped
    send_packet_text("-4.36335");
    // field not reached: keep the last rate
    send_packet_text("");
    // all-ones byte as the first field char stops the parse at zero
    send_char(CHAR_DOLLAR);
    send_char(8'hFF);
    send_char(CHAR_AT);
    // '$' mid-packet restarts at position 0; an all-zero byte ends the parse
    send_char(CHAR_DOLLAR);
    send_text("9");
    send_char(CHAR_DOLLAR);
    send_text("+2");
    send_char(8'h00);
    send_char(CHAR_AT);
    // above the top of the scale: saturate high
    send_packet_text("4.9");
  endtask

  task automatic test_register_map();
    // offset zero puts the '$' itself in the field, which stops the parse
    write_reg(REG_FIELD_OFFSET, 8'd0);
    write_reg(REG_FIELD_LENGTH, 8'hFF);
    send_packet_text("7");
    // undecoded indexes must leave the layout alone
    write_reg(REG_SPARE_LOW, 8'd5);
    write_reg(REG_SPARE_HIGH, 8'h00);
    send_packet_text("7");
    // zero length parses nothing
    write_reg(REG_FIELD_OFFSET, 8'd3);
    write_reg(REG_FIELD_LENGTH, 8'hE0);
    send_packet_text("ab1");
    // one-character field
    write_reg(REG_FIELD_OFFSET, 8'd2);
    write_reg(REG_FIELD_LENGTH, 8'h21);
    send_packet_text("x7");
    // offset beyond any packet: the held rate survives
    write_reg(REG_FIELD_OFFSET, 8'hFF);
    write_reg(REG_FIELD_LENGTH, 8'h10);
    send_packet_text("-1.5");
  endtask

  // Packets longer than the capture window: the field is cut where capture stops.
  task automatic test_packet_overrun();
    write_reg(REG_FIELD_OFFSET, 8'd140);
    write_reg(REG_FIELD_LENGTH, 8'd8);
    send_char(CHAR_DOLLAR);
    send_filler(139);
    send_text("1.23456789");
    send_filler(3);
    send_char(CHAR_AT);
    write_reg(REG_FIELD_OFFSET, 8'd143);
    write_reg(REG_FIELD_LENGTH, 8'd16);
    send_char(CHAR_DOLLAR);
    send_filler(142);
    send_text("39");
    send_filler(2);
    // restart after the overrun, then close with the field untouched
    send_char(CHAR_DOLLAR);
    send_char(CHAR_AT);
  endtask

  // Hold the receiver off while the sender keeps offering packets, so the
  // output register and the clip stage fill and the input backs up.
  task automatic test_output_hold_off();
    int i;
    write_reg(REG_FIELD_OFFSET, 8'd1);
    write_reg(REG_FIELD_LENGTH, 8'd5);
    tx_steady = 1'b1;
    rx_hold_len <= HOLD_OFF_CYCLES;
    rx_hold_tag <= rx_hold_tag + 8'd1;
    for (i = 0; i < 20; i++) begin
      send_char(CHAR_DOLLAR);
      send_char(CHAR_ZERO + 8'($urandom_range(0, 4)));
      send_char(CHAR_POINT);
      send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
      send_char(CHAR_AT);
    end
    tx_steady = 1'b0;
  endtask

  // Pause the sender until every code beat is back, then resume.
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 4; i++) send_rate_packet(1'b1);
    wait_drained();
    for (i = 0; i < 4; i++) send_rate_packet(1'b1);
  endtask

  // Bulk traffic: mostly complete packets with random fields, plus
  // unclosed packets, restarts, noise and stray '@' beats.
  task automatic test_random_packets();
    int pkts;
    int r;
    int n;
    int i;
    pkts = 0;
    while (chars_sent < ITEM_TARGET) begin
      if (pkts % 12 == 0) retune_field();
      pkts++;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_rate_packet(1'b1);
      end else if (r < 83) begin
        send_rate_packet(1'b0);
      end else if (r < 88) begin
        send_char(CHAR_DOLLAR);
        send_filler($urandom_range(0, 4));
        send_rate_packet(1'b1);
      end else if (r < 94) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)));
        send_char(CHAR_AT);
      end else begin
        send_char(CHAR_AT);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    char_ch.valid  = 1'b0;
    char_ch.rx_byte = '0;
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_layout();
    test_directed_cases();
    test_register_map();
    test_packet_overrun();
    test_output_hold_off();
    test_drain_pause();
    test_random_packets();

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_packet_field_rate_to_code_unit passed");
    end else begin
      $display("tb_packet_field_rate_to_code_unit failed");
    end
    $finish;
  end

endmodule
